// File: rtl/ddm_pkg.sv
// Shared types, constants and helper functions of the differential drive mixer.
`timescale 1ns / 1ps

package ddm_pkg;

  // Internal speed width: holds the largest speed limit of 1000 with its sign.
  localparam int SPD_W = 11;
  // Width at which sums are formed before saturation.
  localparam int SAT_W = 17;
  // Magnitude of a smoothing difference or a stored speed.
  localparam int OPM_W = 12;
  localparam int WGT_W = 9;
  localparam int PCT_W = 7;
  localparam int PROD_W = OPM_W + WGT_W;
  localparam int SMOOTH_SHIFT = 8;

  // Division by one hundred as a multiplication by a reciprocal.
  localparam int SCL_W = 17;
  localparam int RCP_W = 18;
  localparam int RCP_SHIFT = 24;
  localparam logic [RCP_W-1:0] RCP_100 = 18'd167773;

  // Arc turn speed is DIV_NUM / (ARC_BASE + |radius|).
  localparam int DIV_W = 14;
  localparam int DVR_W = 16;
  localparam int CNT_W = 4;
  localparam logic [DIV_W-1:0] DIV_NUM = 14'd10000;
  localparam logic [DVR_W:0] ARC_BASE = 17'd100;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
  localparam logic [WGT_W-1:0] WGT_MAX = 9'd256;

  localparam int QDEPTH = 2;

  localparam int IN_DATA_W = 64;
  localparam int IN_USER_W = 3;
  localparam int OUT_DATA_W = 40;
  localparam int WHEEL_W = 8;

  // Request codes as they arrive on the input channel.
  localparam logic [IN_USER_W-1:0] REQ_DRIVE = 3'd0;
  localparam logic [IN_USER_W-1:0] REQ_SPIN = 3'd1;
  localparam logic [IN_USER_W-1:0] REQ_STOP = 3'd2;
  localparam logic [IN_USER_W-1:0] REQ_SCALE = 3'd3;
  localparam logic [IN_USER_W-1:0] REQ_SMOOTH = 3'd4;
  localparam logic [IN_USER_W-1:0] REQ_ARC = 3'd5;

  typedef enum logic [2:0] {
    OP_DRIVE,
    OP_SPIN,
    OP_STOP,
    OP_SCALE,
    OP_SMOOTH,
    OP_ARC,
    OP_HOLD
  } ddm_op_t;

  typedef struct packed {
    ddm_op_t                  op;
    logic signed [SPD_W-1:0]  tgt_straight;
    logic signed [SPD_W-1:0]  tgt_turn;
    logic [DVR_W-1:0]         arc_div;
    logic                     arc_neg;
    logic                     arc_zero;
    logic [WGT_W-1:0]         weight;
    logic [PCT_W-1:0]         percent;
  } ddm_cmd_t;

  // Last member sits in the lowest bits.
  typedef struct packed {
    logic [WHEEL_W-1:0] held_turn;
    logic [WHEEL_W-1:0] held_straight;
    logic               stopped;
    logic [WHEEL_W-1:0] right_wheel;
    logic [WHEEL_W-1:0] left_wheel;
  } ddm_res_t;

  function automatic logic signed [SPD_W-1:0] sat(input logic signed [SAT_W-1:0] v,
                                                   input logic signed [SAT_W-1:0] lim);
    logic signed [SAT_W-1:0] r;
    if (v > lim) begin
      r = lim;
    end else if (v < -lim) begin
      r = -lim;
    end else begin
      r = v;
    end
    return r[SPD_W-1:0];
  endfunction

  function automatic logic signed [SAT_W-1:0] ext(input logic signed [SPD_W-1:0] v);
    return $signed({{(SAT_W-SPD_W){v[SPD_W-1]}}, v});
  endfunction

  function automatic logic signed [SAT_W-1:0] sgn(input logic [SAT_W-2:0] mag,
                                                   input logic neg);
    logic signed [SAT_W-1:0] m;
    m = $signed({1'b0, mag});
    return neg ? -m : m;
  endfunction

endpackage

// File: rtl/ddm_front.sv
// Front end: accepts input transactions, clamps and classifies them for the queue.
`timescale 1ns / 1ps

module ddm_front #(
  parameter int SPEED_LIMIT = 100
) (
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // straight_cmd, turn_cmd, arc_radius, smooth_weight, scale_percent
  input  logic [ddm_pkg::IN_DATA_W-1:0] in_tdata,
  // req_type
  input  logic [ddm_pkg::IN_USER_W-1:0] in_tuser,
  input  logic                          q_full,
  output logic                          q_push,
  output ddm_pkg::ddm_cmd_t             q_cmd
);

  localparam logic signed [ddm_pkg::SAT_W-1:0] LIM = ddm_pkg::SAT_W'(SPEED_LIMIT);

  logic signed [15:0]               s_cmd;
  logic signed [15:0]               t_cmd;
  logic signed [15:0]               rad;
  logic [ddm_pkg::WGT_W-1:0]        w_in;
  logic [ddm_pkg::PCT_W-1:0]        p_in;
  logic [ddm_pkg::DVR_W:0]          rad_mag;
  logic [ddm_pkg::DVR_W:0]          div_sum;

  assign s_cmd = in_tdata[15:0];
  assign t_cmd = in_tdata[31:16];
  assign rad   = in_tdata[47:32];
  assign w_in  = in_tdata[56:48];
  assign p_in  = in_tdata[63:57];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // A radius of -32768 has a magnitude that only fits with the extra bit.
  assign rad_mag = rad[15] ? (17'd0 - {1'b1, rad}) : {1'b0, rad};
  assign div_sum = ddm_pkg::ARC_BASE + rad_mag;

  always_comb begin
    q_cmd.tgt_straight = ddm_pkg::sat($signed({s_cmd[15], s_cmd}), LIM);
    q_cmd.tgt_turn     = ddm_pkg::sat($signed({t_cmd[15], t_cmd}), LIM);
    q_cmd.arc_div      = div_sum[ddm_pkg::DVR_W-1:0];
    q_cmd.arc_neg      = rad[15];
    q_cmd.arc_zero     = (rad == 16'sd0);
    q_cmd.weight       = (w_in > ddm_pkg::WGT_MAX) ? ddm_pkg::WGT_MAX : w_in;
    q_cmd.percent      = (p_in > ddm_pkg::PCT_MAX) ? ddm_pkg::PCT_MAX : p_in;
    unique case (in_tuser)
      ddm_pkg::REQ_DRIVE:  q_cmd.op = ddm_pkg::OP_DRIVE;
      ddm_pkg::REQ_SPIN:   q_cmd.op = ddm_pkg::OP_SPIN;
      ddm_pkg::REQ_STOP:   q_cmd.op = ddm_pkg::OP_STOP;
      ddm_pkg::REQ_SCALE:  q_cmd.op = ddm_pkg::OP_SCALE;
      ddm_pkg::REQ_SMOOTH: q_cmd.op = ddm_pkg::OP_SMOOTH;
      ddm_pkg::REQ_ARC:    q_cmd.op = ddm_pkg::OP_ARC;
      default:             q_cmd.op = ddm_pkg::OP_HOLD;
    endcase
  end

endmodule

// File: rtl/ddm_fifo.sv
// Short command queue between the front end and the execution sequencer.
`timescale 1ns / 1ps

module ddm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ddm_pkg::ddm_cmd_t push_data,
  input  logic              pop,
  output ddm_pkg::ddm_cmd_t pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PW = $clog2(ddm_pkg::QDEPTH);
  localparam int CW = $clog2(ddm_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(ddm_pkg::QDEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ddm_pkg::QDEPTH);

  ddm_pkg::ddm_cmd_t mem_r [ddm_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == FULL_CNT);
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("command pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("command popped from an empty queue");

endmodule

// File: rtl/ddm_back.sv
// Execution sequencer: updates the held speeds, mixes the wheels and registers the result.
`timescale 1ns / 1ps

module ddm_back #(
  parameter int SPEED_LIMIT = 100
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  output logic                           q_pop,
  input  ddm_pkg::ddm_cmd_t              q_cmd,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ddm_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam logic signed [ddm_pkg::SAT_W-1:0] LIM = ddm_pkg::SAT_W'(SPEED_LIMIT);
  localparam int SPD_W = ddm_pkg::SPD_W;
  localparam int SAT_W = ddm_pkg::SAT_W;
  localparam int FULL_W = ddm_pkg::SCL_W + ddm_pkg::RCP_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_RCP  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_MIX  = 5'b10000
  } ddm_state_t;

  ddm_state_t state_r, state_nxt;
  ddm_pkg::ddm_cmd_t cmd_r, cmd_nxt;
  logic signed [SPD_W-1:0] straight_r, straight_nxt;
  logic signed [SPD_W-1:0] turn_r, turn_nxt;
  logic [ddm_pkg::PROD_W-1:0] prod_s_r, prod_s_nxt, prod_t_r, prod_t_nxt;
  logic neg_s_r, neg_s_nxt, neg_t_r, neg_t_nxt;
  logic [SPD_W-1:0] quo_s_r, quo_s_nxt, quo_t_r, quo_t_nxt;
  logic [ddm_pkg::DVR_W-1:0] rem_r, rem_nxt;
  logic [ddm_pkg::DIV_W-1:0] div_q_r, div_q_nxt;
  logic [ddm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  ddm_pkg::ddm_res_t out_data_r, out_data_nxt;

  logic smooth;
  logic signed [SAT_W-1:0] op_s, op_t, mag_s, mag_t;
  logic [ddm_pkg::WGT_W-1:0] fac;
  logic [FULL_W-1:0] rcp_s, rcp_t;
  logic [ddm_pkg::DVR_W:0] trial;
  logic trial_ge;
  logic [ddm_pkg::PROD_W-1:0] step_s, step_t;
  logic signed [SAT_W-1:0] new_s, new_t;
  logic signed [SPD_W-1:0] ns, nt, left, right;
  logic load;

  assign smooth = (cmd_r.op == ddm_pkg::OP_SMOOTH);

  // Operands of the scale and smooth multiplications, split into magnitude and sign.
  always_comb begin
    op_s  = smooth ? ddm_pkg::ext(cmd_r.tgt_straight) - ddm_pkg::ext(straight_r)
                   : ddm_pkg::ext(straight_r);
    op_t  = smooth ? ddm_pkg::ext(cmd_r.tgt_turn) - ddm_pkg::ext(turn_r)
                   : ddm_pkg::ext(turn_r);
    mag_s = op_s[SAT_W-1] ? -op_s : op_s;
    mag_t = op_t[SAT_W-1] ? -op_t : op_t;
    fac   = smooth ? cmd_r.weight : ddm_pkg::WGT_W'(cmd_r.percent);
  end

  assign rcp_s = prod_s_r[ddm_pkg::SCL_W-1:0] * ddm_pkg::RCP_100;
  assign rcp_t = prod_t_r[ddm_pkg::SCL_W-1:0] * ddm_pkg::RCP_100;

  // One restoring step of the arc divider per cycle, most significant bit first.
  assign trial    = {rem_r, ddm_pkg::DIV_NUM[cnt_r]};
  assign trial_ge = (trial >= {1'b0, cmd_r.arc_div});

  assign step_s = prod_s_r >> ddm_pkg::SMOOTH_SHIFT;
  assign step_t = prod_t_r >> ddm_pkg::SMOOTH_SHIFT;

  always_comb begin
    unique case (cmd_r.op)
      ddm_pkg::OP_DRIVE: begin
        new_s = ddm_pkg::ext(cmd_r.tgt_straight);
        new_t = ddm_pkg::ext(cmd_r.tgt_turn);
      end
      ddm_pkg::OP_SPIN: begin
        new_s = '0;
        new_t = ddm_pkg::ext(cmd_r.tgt_turn);
      end
      ddm_pkg::OP_STOP: begin
        new_s = '0;
        new_t = '0;
      end
      ddm_pkg::OP_SCALE: begin
        new_s = ddm_pkg::sgn((SAT_W-1)'(quo_s_r), neg_s_r);
        new_t = ddm_pkg::sgn((SAT_W-1)'(quo_t_r), neg_t_r);
      end
      ddm_pkg::OP_SMOOTH: begin
        new_s = ddm_pkg::ext(straight_r) +
                ddm_pkg::sgn(step_s[SAT_W-2:0], neg_s_r);
        new_t = ddm_pkg::ext(turn_r) +
                ddm_pkg::sgn(step_t[SAT_W-2:0], neg_t_r);
      end
      ddm_pkg::OP_ARC: begin
        new_s = ddm_pkg::ext(cmd_r.tgt_straight);
        new_t = cmd_r.arc_zero ? '0
              : ddm_pkg::sgn((SAT_W-1)'(div_q_r), cmd_r.arc_neg);
      end
      default: begin
        new_s = ddm_pkg::ext(straight_r);
        new_t = ddm_pkg::ext(turn_r);
      end
    endcase
    ns = ddm_pkg::sat(new_s, LIM);
    nt = ddm_pkg::sat(new_t, LIM);
    if (cmd_r.op == ddm_pkg::OP_STOP) begin
      left  = '0;
      right = '0;
    end else if (cmd_r.op == ddm_pkg::OP_SPIN) begin
      left  = -nt;
      right = nt;
    end else begin
      left  = ddm_pkg::sat(ddm_pkg::ext(ns) - ddm_pkg::ext(nt), LIM);
      right = ddm_pkg::sat(ddm_pkg::ext(ns) + ddm_pkg::ext(nt), LIM);
    end
  end

  assign load  = (state_r == ST_MIX) && (!out_valid_r || out_tready);
  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    straight_nxt = straight_r;
    turn_nxt     = turn_r;
    prod_s_nxt   = prod_s_r;
    prod_t_nxt   = prod_t_r;
    neg_s_nxt    = neg_s_r;
    neg_t_nxt    = neg_t_r;
    quo_s_nxt    = quo_s_r;
    quo_t_nxt    = quo_t_r;
    rem_nxt      = rem_r;
    div_q_nxt    = div_q_r;
    cnt_nxt      = cnt_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          cmd_nxt = q_cmd;
          rem_nxt = '0;
          cnt_nxt = ddm_pkg::CNT_W'(ddm_pkg::DIV_W - 1);
          if (q_cmd.op == ddm_pkg::OP_SCALE || q_cmd.op == ddm_pkg::OP_SMOOTH) begin
            state_nxt = ST_MUL;
          end else if (q_cmd.op == ddm_pkg::OP_ARC && !q_cmd.arc_zero) begin
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_MIX;
          end
        end
      end
      ST_MUL: begin
        prod_s_nxt = mag_s[ddm_pkg::OPM_W-1:0] * fac;
        prod_t_nxt = mag_t[ddm_pkg::OPM_W-1:0] * fac;
        neg_s_nxt  = op_s[SAT_W-1];
        neg_t_nxt  = op_t[SAT_W-1];
        state_nxt  = smooth ? ST_MIX : ST_RCP;
      end
      ST_RCP: begin
        quo_s_nxt = rcp_s[ddm_pkg::RCP_SHIFT +: SPD_W];
        quo_t_nxt = rcp_t[ddm_pkg::RCP_SHIFT +: SPD_W];
        state_nxt = ST_MIX;
      end
      ST_DIV: begin
        rem_nxt   = trial_ge ? ddm_pkg::DVR_W'(trial - {1'b0, cmd_r.arc_div})
                             : trial[ddm_pkg::DVR_W-1:0];
        div_q_nxt = {div_q_r[ddm_pkg::DIV_W-2:0], trial_ge};
        if (cnt_r == '0) begin
          state_nxt = ST_MIX;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_MIX: begin
        if (load) begin
          straight_nxt  = ns;
          turn_nxt      = nt;
          out_valid_nxt = 1'b1;
          out_data_nxt.left_wheel    = left[ddm_pkg::WHEEL_W-1:0];
          out_data_nxt.right_wheel   = right[ddm_pkg::WHEEL_W-1:0];
          out_data_nxt.stopped       = (cmd_r.op == ddm_pkg::OP_STOP);
          out_data_nxt.held_straight = ns[ddm_pkg::WHEEL_W-1:0];
          out_data_nxt.held_turn     = nt[ddm_pkg::WHEEL_W-1:0];
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      straight_r  <= '0;
      turn_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      straight_r  <= straight_nxt;
      turn_r      <= turn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    prod_s_r   <= prod_s_nxt;
    prod_t_r   <= prod_t_nxt;
    neg_s_r    <= neg_s_nxt;
    neg_t_r    <= neg_t_nxt;
    quo_s_r    <= quo_s_nxt;
    quo_t_r    <= quo_t_nxt;
    rem_r      <= rem_nxt;
    div_q_r    <= div_q_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ddm_pkg::OUT_DATA_W'(out_data_r);

  a_straight_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ddm_pkg::ext(straight_r) <= LIM) && (ddm_pkg::ext(straight_r) >= -LIM))
    else $error("held straight speed outside the limit");
  a_turn_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ddm_pkg::ext(turn_r) <= LIM) && (ddm_pkg::ext(turn_r) >= -LIM))
    else $error("held turn speed outside the limit");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> ({1'b0, rem_r} < {1'b0, cmd_r.arc_div}))
    else $error("arc divider remainder not below the divisor");

endmodule

// File: rtl/differential_drive_mixer_top.sv
// Top level of the differential drive mixer: front end, command queue and sequencer.
// Each command passes through the sequencer states in turn: drive, spin, stop and unused
// codes go straight to the mix, smooth multiplies first, scale multiplies and then
// applies the reciprocal, and an arc with a non-zero radius runs a 14-step restoring
// divider, one quotient bit per cycle. The sequencer takes one command at a time.
// Synchronous active-low reset clears the held speeds to zero and empties the queue.
`timescale 1ns / 1ps

module differential_drive_mixer_top #(
  parameter int SPEED_LIMIT = 100
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // straight_cmd[15:0], turn_cmd[31:16], arc_radius[47:32], smooth_weight[56:48],
  // scale_percent[63:57]
  input  logic [ddm_pkg::IN_DATA_W-1:0]  in_tdata,
  // req_type[2:0]
  input  logic [ddm_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // left_wheel[7:0], right_wheel[15:8], motors_stopped[16], held_straight[24:17],
  // held_turn[32:25], zero padding above
  output logic [ddm_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  ddm_pkg::ddm_cmd_t push_cmd;
  ddm_pkg::ddm_cmd_t pop_cmd;

  ddm_front #(
    .SPEED_LIMIT(SPEED_LIMIT)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  ddm_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_cmd),
    .pop      (q_pop),
    .pop_data (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  ddm_back #(
    .SPEED_LIMIT(SPEED_LIMIT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

// File: tb/tb_differential_drive_mixer_top.sv
// Self-checking testbench of the differential drive mixer with its own speed predictor.
`timescale 1ns / 1ps

module tb_differential_drive_mixer_top;

  localparam int SPEED_LIMIT = 100;
  // The two request codes that carry no command of their own.
  localparam logic [ddm_pkg::IN_USER_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [ddm_pkg::IN_USER_W-1:0] REQ_SPARE_B = 3'd7;
  localparam int RANDOM_ITEMS = 500;
  localparam int DRAIN_LIMIT = 4000;

  // Payload of one command, laid out as it travels on in_tdata.
  typedef struct packed {
    logic [ddm_pkg::PCT_W-1:0] scale_percent;
    logic [ddm_pkg::WGT_W-1:0] smooth_weight;
    logic signed [15:0]        arc_radius;
    logic signed [15:0]        turn_cmd;
    logic signed [15:0]        straight_cmd;
  } drive_cmd_t;

  typedef struct {
    logic [ddm_pkg::IN_USER_W-1:0] req;
    drive_cmd_t                    data;
  } drive_item_t;

  typedef struct {
    logic [ddm_pkg::WHEEL_W-1:0] left_wheel;
    logic [ddm_pkg::WHEEL_W-1:0] right_wheel;
    logic                        motors_stopped;
    logic [ddm_pkg::WHEEL_W-1:0] held_straight;
    logic [ddm_pkg::WHEEL_W-1:0] held_turn;
  } wheel_res_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [ddm_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [ddm_pkg::IN_USER_W-1:0]  in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [ddm_pkg::OUT_DATA_W-1:0] out_tdata;

  drive_item_t cmd_pending_q[$];
  wheel_res_t  wheel_expect_q[$];
  int          mismatch_count = 0;
  int          held_straight_now = 0;
  int          held_turn_now = 0;
  logic        in_taken = 1'b0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_left = 0;
  int          ready_mode = 0;
  logic [15:0] ready_bits = '1;

  differential_drive_mixer_top #(
    .SPEED_LIMIT(SPEED_LIMIT)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int clamp_speed(input int v);
    if (v > SPEED_LIMIT) begin
      return SPEED_LIMIT;
    end else if (v < -SPEED_LIMIT) begin
      return -SPEED_LIMIT;
    end
    return v;
  endfunction

  // Applies one command to the held speeds and returns the wheel result it produces.
  function automatic wheel_res_t mix_command(input logic [ddm_pkg::IN_USER_W-1:0] req,
                                             input drive_cmd_t c);
    int         s_tgt;
    int         t_tgt;
    int         rad;
    int         wgt;
    int         pct;
    int         arc_turn;
    int         left;
    int         right;
    wheel_res_t r;
    s_tgt = clamp_speed(int'(c.straight_cmd));
    t_tgt = clamp_speed(int'(c.turn_cmd));
    rad = int'(c.arc_radius);
    wgt = int'(c.smooth_weight);
    pct = int'(c.scale_percent);
    r.motors_stopped = 1'b0;
    case (req)
      ddm_pkg::REQ_DRIVE: begin
        held_straight_now = s_tgt;
        held_turn_now = t_tgt;
      end
      ddm_pkg::REQ_SPIN: begin
        held_straight_now = 0;
        held_turn_now = t_tgt;
      end
      ddm_pkg::REQ_STOP: begin
        held_straight_now = 0;
        held_turn_now = 0;
        r.motors_stopped = 1'b1;
      end
      ddm_pkg::REQ_SCALE: begin
        if (pct > 100) pct = 100;
        held_straight_now = clamp_speed((held_straight_now * pct) / 100);
        held_turn_now = clamp_speed((held_turn_now * pct) / 100);
      end
      ddm_pkg::REQ_SMOOTH: begin
        if (wgt > 256) wgt = 256;
        held_straight_now = clamp_speed(held_straight_now
                                        + ((s_tgt - held_straight_now) * wgt) / 256);
        held_turn_now = clamp_speed(held_turn_now + ((t_tgt - held_turn_now) * wgt) / 256);
      end
      ddm_pkg::REQ_ARC: begin
        arc_turn = 0;
        if (rad != 0) begin
          arc_turn = 10000 / (100 + (rad < 0 ? -rad : rad));
          if (rad < 0) arc_turn = -arc_turn;
        end
        held_straight_now = s_tgt;
        held_turn_now = clamp_speed(arc_turn);
      end
      default: begin
      end
    endcase
    if (req == ddm_pkg::REQ_STOP) begin
      left = 0;
      right = 0;
    end else if (req == ddm_pkg::REQ_SPIN) begin
      left = -held_turn_now;
      right = held_turn_now;
    end else begin
      left = clamp_speed(held_straight_now - held_turn_now);
      right = clamp_speed(held_straight_now + held_turn_now);
    end
    r.left_wheel = left[ddm_pkg::WHEEL_W-1:0];
    r.right_wheel = right[ddm_pkg::WHEEL_W-1:0];
    r.held_straight = held_straight_now[ddm_pkg::WHEEL_W-1:0];
    r.held_turn = held_turn_now[ddm_pkg::WHEEL_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic queue_cmd(input logic [ddm_pkg::IN_USER_W-1:0] req, input int s,
                           input int t, input int rad, input int wgt, input int pct);
    drive_item_t it;
    it.req = req;
    it.data.straight_cmd = s[15:0];
    it.data.turn_cmd = t[15:0];
    it.data.arc_radius = rad[15:0];
    it.data.smooth_weight = wgt[ddm_pkg::WGT_W-1:0];
    it.data.scale_percent = pct[ddm_pkg::PCT_W-1:0];
    cmd_pending_q.push_back(it);
  endtask

  // Mostly speeds around the limit, now and then anything the field can hold.
  function automatic int rand_speed();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, 260) - 130;
    if (sel < 8) return $urandom_range(0, 6) - 3 + (($urandom_range(0, 1) == 1) ? 100 : -100);
    return $urandom_range(0, 65535) - 32768;
  endfunction

  function automatic int rand_radius();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel < 6) return $urandom_range(0, 600) - 300;
    return $urandom_range(0, 65535) - 32768;
  endfunction

  // Sender: bursts of transactions separated by random gaps; idle data is noise.
  always @(negedge clk) begin : drive_input
    drive_item_t nxt;
    logic        hold;
    if (rst_n) begin
      hold = in_tvalid && !in_taken;
      if (!hold && gap_left == 0 && cmd_pending_q.size() > 0) begin
        nxt = cmd_pending_q.pop_front();
        in_tdata <= nxt.data;
        in_tuser <= nxt.req;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else if (!hold) begin
        if (gap_left > 0) gap_left--;
        in_tdata <= {$urandom, $urandom};
        in_tuser <= ddm_pkg::IN_USER_W'($urandom);
        in_tvalid <= 1'b0;
      end
      in_taken = 1'b0;
    end
  end

  // Receiver: periods of steady readiness alternate with a rotating stall pattern.
  always @(negedge clk) begin
    if (rst_n) begin
      if (ready_left == 0) begin
        ready_left = $urandom_range(8, 64);
        ready_mode = $urandom_range(0, 2);
        ready_bits = 16'($urandom);
      end
      ready_left--;
      ready_bits = {ready_bits[14:0], ready_bits[15]};
      out_tready <= (ready_mode == 0) ? 1'b1 : ready_bits[0];
    end
  end

  always @(posedge clk) begin : watch_ports
    wheel_res_t want;
    if (rst_n && in_tvalid && in_tready) begin
      wheel_expect_q.push_back(mix_command(in_tuser, drive_cmd_t'(in_tdata)));
      in_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (wheel_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%0h", out_tdata));
      end else begin
        want = wheel_expect_q.pop_front();
        check_field("left_wheel", out_tdata[7:0], want.left_wheel);
        check_field("right_wheel", out_tdata[15:8], want.right_wheel);
        check_field("motors_stopped", out_tdata[16], want.motors_stopped);
        check_field("held_straight", out_tdata[24:17], want.held_straight);
        check_field("held_turn", out_tdata[32:25], want.held_turn);
        check_field("padding", out_tdata[39:33], 0);
      end
    end
  end

  initial begin
    #5000000;
    $display("differential_drive_mixer_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    int sel;
    int drain_cycles;
    logic [ddm_pkg::IN_USER_W-1:0] req;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;

    // Clamping at both ends of the speed fields, then each command in turn.
    queue_cmd(ddm_pkg::REQ_DRIVE, 32767, -32768, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_DRIVE, -32768, 32767, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_DRIVE, 101, -101, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_DRIVE, 100, 100, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_SCALE, 0, 0, 0, 0, 127);
    queue_cmd(ddm_pkg::REQ_SCALE, 0, 0, 0, 0, 67);
    queue_cmd(ddm_pkg::REQ_DRIVE, -99, 37, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_SCALE, 0, 0, 0, 0, 33);
    queue_cmd(ddm_pkg::REQ_SCALE, 0, 0, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_SPIN, 55, -32768, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_SPIN, -1, 32767, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_SMOOTH, -32768, 50, 0, 128, 0);
    queue_cmd(ddm_pkg::REQ_SMOOTH, 77, -77, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_SMOOTH, 77, -77, 0, 511, 0);
    queue_cmd(ddm_pkg::REQ_SMOOTH, -100, 100, 0, 257, 0);
    queue_cmd(REQ_SPARE_A, 0, 0, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_STOP, 100, 100, 100, 256, 100);
    queue_cmd(ddm_pkg::REQ_ARC, 60, 0, 0, 0, 0);
    queue_cmd(ddm_pkg::REQ_ARC, -60, 0, 1, 0, 0);
    queue_cmd(ddm_pkg::REQ_ARC, 32767, 0, -1, 0, 0);
    queue_cmd(ddm_pkg::REQ_ARC, 10, 0, 32767, 0, 0);
    queue_cmd(ddm_pkg::REQ_ARC, -32768, 0, -32768, 0, 0);
    queue_cmd(ddm_pkg::REQ_ARC, 0, 0, -150, 0, 0);
    queue_cmd(REQ_SPARE_A, 100, 100, 5, 5, 5);
    queue_cmd(REQ_SPARE_B, -100, -100, 5, 5, 5);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 19);
      req = (sel < 18) ? ddm_pkg::IN_USER_W'(sel % 6)
                       : ((sel == 18) ? REQ_SPARE_A : REQ_SPARE_B);
      queue_cmd(req, rand_speed(), rand_speed(), rand_radius(),
                $urandom_range(0, 511), $urandom_range(0, 127));
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_pending_q.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    drain_cycles = 0;
    while (wheel_expect_q.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    if (wheel_expect_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", wheel_expect_q.size()));
    end
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("differential_drive_mixer_top regression: pass");
    end else begin
      $display("differential_drive_mixer_top regression: fail");
    end
    $finish;
  end

endmodule
